[rtl/htfd_pkg.sv]
package htfd_pkg;

   localparam int DATA_W = 8;
   localparam int WORD_W = 16;
   localparam int TEMP_W = 15;
   localparam int HUM_W = 14;
   localparam int RSP_DATA_W = 32;

   localparam logic [DATA_W-1:0] CRC_POLY = 8'h31;
   localparam logic [DATA_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [DATA_W-1:0] CRC_MSB = 8'h80;

   localparam logic [12:0] TEMP_MUL = 13'd4375;
   localparam int TEMP_SHIFT = 14;
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;
   localparam logic [9:0] HUM_MUL = 10'd625;
   localparam int HUM_SHIFT = 12;

   localparam logic [2:0] POS_TEMP_HI = 3'd0;
   localparam logic [2:0] POS_TEMP_LO = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_HI = 3'd3;
   localparam logic [2:0] POS_HUM_LO = 3'd4;
   localparam logic [2:0] POS_HUM_CRC = 3'd5;

   typedef struct packed {
      logic last;
      logic ok;
   } frame_result_type;

   function automatic logic [DATA_W-1:0] crc8_byte(input logic [DATA_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] v;
      v = crc ^ b;
      for (int i = 0; i < DATA_W; i++) begin
         if ((v & CRC_MSB) != '0) begin
            v = (v << 1) ^ CRC_POLY;
         end else begin
            v = v << 1;
         end
      end
      return v;
   endfunction

endpackage

[rtl/htfd_frame.sv]
module htfd_frame
   import htfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [DATA_W-1:0]   data_byte,
   input  logic                frame_start,
   output frame_result_type    result,
   output logic [WORD_W-1:0]   temp_word,
   output logic [WORD_W-1:0]   hum_word
);

   logic [2:0]        frame_position_ff, frame_position_in;
   logic [DATA_W-1:0] running_crc_ff, running_crc_in;
   logic              first_word_ok_ff, first_word_ok_in;
   logic [WORD_W-1:0] temp_word_ff, temp_word_in;
   logic [WORD_W-1:0] hum_word_ff, hum_word_in;
   logic [2:0]        pos;
   logic [DATA_W-1:0] crc_base;
   logic [DATA_W-1:0] crc_next;

   always_comb begin
      pos = (frame_start || frame_position_ff > POS_HUM_CRC) ? POS_TEMP_HI : frame_position_ff;
      crc_base = (pos == POS_TEMP_HI) ? CRC_INIT : running_crc_ff;
      crc_next = crc8_byte(crc_base, data_byte);
      frame_position_in = pos + 3'd1;
      running_crc_in = crc_next;
      first_word_ok_in = first_word_ok_ff;
      temp_word_in = temp_word_ff;
      hum_word_in = hum_word_ff;
      result.last = 1'b0;
      result.ok = 1'b0;
      unique case (pos)
         POS_TEMP_HI: begin
            temp_word_in = {data_byte, temp_word_ff[DATA_W-1:0]};
         end
         POS_TEMP_LO: begin
            temp_word_in = {temp_word_ff[WORD_W-1:DATA_W], data_byte};
         end
         POS_TEMP_CRC: begin
            first_word_ok_in = (data_byte == running_crc_ff);
            running_crc_in = CRC_INIT;
         end
         POS_HUM_HI: begin
            hum_word_in = {data_byte, hum_word_ff[DATA_W-1:0]};
         end
         POS_HUM_LO: begin
            hum_word_in = {hum_word_ff[WORD_W-1:DATA_W], data_byte};
         end
         default: begin
            result.last = 1'b1;
            result.ok = first_word_ok_ff && (data_byte == running_crc_ff);
            running_crc_in = CRC_INIT;
            frame_position_in = POS_TEMP_HI;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_position_ff <= POS_TEMP_HI;
         running_crc_ff <= CRC_INIT;
         first_word_ok_ff <= 1'b0;
      end else if (advance) begin
         frame_position_ff <= frame_position_in;
         running_crc_ff <= running_crc_in;
         first_word_ok_ff <= first_word_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         temp_word_ff <= temp_word_in;
         hum_word_ff <= hum_word_in;
      end
   end

   assign temp_word = temp_word_ff;
   assign hum_word = hum_word_ff;

`ifndef SYNTH
   a_position_range: assert property (@(posedge clock) disable iff (reset)
      frame_position_ff <= POS_HUM_CRC)
      else $error("frame position beyond the last byte");
`endif

endmodule

[rtl/htfd_out.sv]
module htfd_out
   import htfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  ok,
   input  logic [WORD_W-1:0]     temp_word,
   input  logic [WORD_W-1:0]     hum_word,
   input  logic                  take,
   output logic                  out_valid,
   output logic                  status,
   output logic [TEMP_W-1:0]     temp_centi,
   output logic [HUM_W-1:0]      hum_centi
);

   logic              out_valid_ff, out_valid_in;
   logic              status_ff;
   logic [TEMP_W-1:0] temp_centi_ff;
   logic [HUM_W-1:0]  hum_centi_ff;
   logic [28:0]       temp_prod;
   logic [25:0]       hum_prod;
   logic [TEMP_W-1:0] temp_scaled;
   logic [HUM_W-1:0]  hum_scaled;

   always_comb begin
      temp_prod = 29'(TEMP_MUL) * 29'(temp_word);
      hum_prod = 26'(HUM_MUL) * 26'(hum_word);
      temp_scaled = TEMP_W'(temp_prod >> TEMP_SHIFT);
      hum_scaled = HUM_W'(hum_prod >> HUM_SHIFT);
      if (load) begin
         out_valid_in = 1'b1;
      end else if (take) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= !ok;
         temp_centi_ff <= ok ? (temp_scaled - TEMP_OFFSET) : '0;
         hum_centi_ff <= ok ? hum_scaled : '0;
      end
   end

   assign out_valid = out_valid_ff;
   assign status = status_ff;
   assign temp_centi = temp_centi_ff;
   assign hum_centi = hum_centi_ff;

`ifndef SYNTH
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff |-> temp_centi_ff == '0 && hum_centi_ff == '0)
      else $error("failed frame carries non-zero values");
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !status_ff |-> hum_centi_ff <= HUM_W'(9999))
      else $error("humidity beyond full scale");
`endif

endmodule

[rtl/humidity_temp_frame_decode.sv]
// Decodes the six-byte measurement frame of a humidity and temperature sensor.
// Requests arrive on the req_ channel, one frame byte per request, with
// req_tuser high on the first byte of a frame; a byte at the start position
// opens a new frame even without it, so frames may follow back to back.
// Each word is checked with CRC-8 (polynomial 0x31, initial value 0xFF).
// On the sixth byte one result leaves on the rsp_ channel: rsp_tuser is the
// status (high on a CRC mismatch, values then zero), rsp_tdata carries the
// temperature in hundredths of a degree and the humidity in hundredths of a
// percent. Bytes one to five give no result.
// One byte is taken every cycle while req_tready is high. A byte passes an
// input register and, once it may advance, is decoded into the output register,
// from which its result is presented; the CRC step and the two constant
// multiplies each fit in one register-to-register path.
// Synchronous reset returns the frame position and the CRC to their initial
// values and clears both valid flags.
// While the receiver stalls with a result waiting, the byte held in the
// input register still advances unless it would finish a frame, in which
// case req_tready drops until the waiting result is taken.
module humidity_temp_frame_decode
   import htfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // data_byte
   input  logic                   req_tuser,   // frame_start
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // temp_centi, hum_centi, zero fill
   output logic                   rsp_tuser    // status
);

   logic              s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0] s1_byte_ff;
   logic              s1_start_ff;
   logic              s1_advance;
   logic              req_accept;
   frame_result_type  result;
   logic [WORD_W-1:0] temp_word;
   logic [WORD_W-1:0] hum_word;
   logic [TEMP_W-1:0] temp_centi;
   logic [HUM_W-1:0]  hum_centi;

   assign s1_advance = s1_valid_ff && (!result.last || !rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_tdata;
         s1_start_ff <= req_tuser;
      end
   end

   htfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_advance),
      .data_byte   (s1_byte_ff),
      .frame_start (s1_start_ff),
      .result      (result),
      .temp_word   (temp_word),
      .hum_word    (hum_word)
   );

   htfd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_advance && result.last),
      .ok         (result.ok),
      .temp_word  (temp_word),
      .hum_word   (hum_word),
      .take       (rsp_tready),
      .out_valid  (rsp_tvalid),
      .status     (rsp_tuser),
      .temp_centi (temp_centi),
      .hum_centi  (hum_centi)
   );

   assign rsp_tdata = {{(RSP_DATA_W - TEMP_W - HUM_W){1'b0}}, hum_centi, temp_centi};

`ifndef SYNTH
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |-> !req_tready)
      else $error("request taken while the input register is blocked");
   a_last_loads: assert property (@(posedge clock) disable iff (reset)
      s1_advance && result.last |=> rsp_tvalid)
      else $error("finished frame did not reach the output register");
`endif

endmodule

[test/tb_humidity_temp_frame_decode.sv]
module tb_humidity_temp_frame_decode;
   timeunit 1ns;
   timeprecision 1ps;
   import htfd_pkg::*;

   typedef struct packed {
      logic              status;
      logic [TEMP_W-1:0] temp;
      logic [HUM_W-1:0]  hum;
   } reading_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              start;
      logic              typed;
      reading_type       want;
   } stim_row_type;

   localparam reading_type NONE = '0;
   localparam reading_type CRC_FAIL = '{1'b1, '0, '0};
   localparam reading_type COLD_WET = '{1'b0, TEMP_W'(-4500), HUM_W'(9999)};
   localparam reading_type HOT_DRY = '{1'b0, TEMP_W'(12999), HUM_W'(0)};

   localparam int N_ROWS = 27;
   localparam stim_row_type DIRECTED [N_ROWS] = '{
      '{8'h00, 1'b1, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE}, '{8'h81, 1'b0, 1'b0, NONE},
      '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hAC, 1'b0, 1'b1, COLD_WET},
      '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE}, '{8'hAC, 1'b0, 1'b0, NONE},
      '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE}, '{8'h81, 1'b0, 1'b1, HOT_DRY},
      '{8'hBE, 1'b1, 1'b0, NONE}, '{8'hEF, 1'b0, 1'b0, NONE}, '{8'h92, 1'b0, 1'b0, NONE},
      '{8'hBE, 1'b1, 1'b0, NONE}, '{8'hEF, 1'b0, 1'b0, NONE}, '{8'h92, 1'b0, 1'b0, NONE},
      '{8'hBE, 1'b0, 1'b0, NONE}, '{8'hEF, 1'b0, 1'b0, NONE}, '{8'h92, 1'b0, 1'b0, NONE},
      '{8'hBE, 1'b1, 1'b0, NONE}, '{8'hEF, 1'b0, 1'b0, NONE}, '{8'h92, 1'b0, 1'b0, NONE},
      '{8'hBE, 1'b0, 1'b0, NONE}, '{8'hEF, 1'b0, 1'b0, NONE}, '{8'h6D, 1'b0, 1'b1, CRC_FAIL}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   logic [2:0]            byte_index = POS_TEMP_HI;
   logic [DATA_W-1:0]     crc_acc = CRC_INIT;
   logic                  temp_crc_good = 1'b0;
   logic [WORD_W-1:0]     raw_temp = '0;
   logic [WORD_W-1:0]     raw_hum = '0;
   reading_type           frame_results[$];

   int idle_pct = 0;
   int stall_pct = 0;
   int bytes_sent = 0;
   int mismatches = 0;

   humidity_temp_frame_decode DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [DATA_W-1:0] crc8_update(input logic [DATA_W-1:0] acc,
                                                     input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] r;
      r = acc ^ b;
      repeat (DATA_W) r = r[DATA_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] word_crc(input logic [WORD_W-1:0] w);
      return crc8_update(crc8_update(CRC_INIT, w[15:8]), w[7:0]);
   endfunction

   function automatic void decode_request(input logic [DATA_W-1:0] b, input logic s);
      logic [2:0]  pos;
      logic [31:0] scaled;
      reading_type r;
      pos = (s || byte_index > POS_HUM_CRC) ? POS_TEMP_HI : byte_index;
      if (pos == POS_TEMP_HI) begin
         crc_acc = CRC_INIT;
      end
      byte_index = pos + 3'd1;
      case (pos)
         POS_TEMP_HI: begin
            raw_temp[15:8] = b;
            crc_acc = crc8_update(crc_acc, b);
         end
         POS_TEMP_LO: begin
            raw_temp[7:0] = b;
            crc_acc = crc8_update(crc_acc, b);
         end
         POS_TEMP_CRC: begin
            temp_crc_good = (b == crc_acc);
            crc_acc = CRC_INIT;
         end
         POS_HUM_HI: begin
            raw_hum[15:8] = b;
            crc_acc = crc8_update(crc_acc, b);
         end
         POS_HUM_LO: begin
            raw_hum[7:0] = b;
            crc_acc = crc8_update(crc_acc, b);
         end
         default: begin
            r = CRC_FAIL;
            if (temp_crc_good && b == crc_acc) begin
               scaled = ((32'd4375 * {16'd0, raw_temp}) >> 14) - 32'd4500;
               r.status = 1'b0;
               r.temp = scaled[TEMP_W-1:0];
               scaled = (32'd625 * {16'd0, raw_hum}) >> 12;
               r.hum = scaled[HUM_W-1:0];
            end
            crc_acc = CRC_INIT;
            byte_index = POS_TEMP_HI;
            frame_results.push_back(r);
         end
      endcase
   endfunction

   task automatic send_byte(input logic [DATA_W-1:0] b, input logic s);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= DATA_W'($urandom_range(255));
         req_tuser <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_request(b, s);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [WORD_W-1:0] t, input logic [WORD_W-1:0] h,
                             input logic [DATA_W-1:0] t_flip,
                             input logic [DATA_W-1:0] h_flip, input logic s);
      send_byte(t[15:8], s);
      send_byte(t[7:0], 1'b0);
      send_byte(word_crc(t) ^ t_flip, 1'b0);
      send_byte(h[15:8], 1'b0);
      send_byte(h[7:0], 1'b0);
      send_byte(word_crc(h) ^ h_flip, 1'b0);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return WORD_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   always @(posedge clock) begin : rsp_side
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result: status %b tdata %h", rsp_tuser, rsp_tdata);
            end
         end else begin
            want = frame_results.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[TEMP_W-1:0] !== want.temp ||
                rsp_tdata[TEMP_W+HUM_W-1:TEMP_W] !== want.hum ||
                rsp_tdata[RSP_DATA_W-1:TEMP_W+HUM_W] !== '0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch: exp %b %0d %0d, got %b %0d %0d fill %b",
                           want.status, $signed(want.temp), want.hum, rsp_tuser,
                           $signed(rsp_tdata[TEMP_W-1:0]), rsp_tdata[TEMP_W+HUM_W-1:TEMP_W],
                           rsp_tdata[RSP_DATA_W-1:TEMP_W+HUM_W]);
               end
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin : stimulus
      int idle_set[4];
      int stall_set[4];
      int target;
      int sel;
      int n;
      idle_set = '{0, 69, 0, 26};
      stall_set = '{0, 0, 69, 26};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         send_byte(DIRECTED[i].data, DIRECTED[i].start);
         if (DIRECTED[i].typed) begin
            frame_results[frame_results.size()-1] = DIRECTED[i].want;
         end
      end

      for (int p = 0; p < 4; p++) begin
         // Hold off new requests until every outstanding result has been taken.
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (frame_results.size() != 0) @(posedge clock);
         idle_pct = idle_set[p];
         stall_pct = stall_set[p];
         target = bytes_sent + 500;
         while (bytes_sent < target) begin
            sel = $urandom_range(99);
            if (sel < 75) begin
               send_frame(pick_word(), pick_word(), '0, '0, 1'($urandom_range(1)));
            end else if (sel < 88) begin
               n = $urandom_range(1, 255);
               if ($urandom_range(1)) begin
                  send_frame(pick_word(), pick_word(), DATA_W'(n), '0, 1'($urandom_range(1)));
               end else begin
                  send_frame(pick_word(), pick_word(), '0, DATA_W'(n), 1'($urandom_range(1)));
               end
            end else if (sel < 95) begin
               n = $urandom_range(1, 5);
               for (int k = 0; k < n; k++) begin
                  send_byte(DATA_W'($urandom_range(255)), k == 0);
               end
            end else begin
               repeat ($urandom_range(1, 8)) begin
                  send_byte(DATA_W'($urandom_range(255)), 1'($urandom_range(1)));
               end
            end
         end
      end

      req_tvalid <= 1'b0;
      while (frame_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0 && frame_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/htfd_pkg.sv
rtl/htfd_frame.sv
rtl/htfd_out.sv
rtl/humidity_temp_frame_decode.sv
test/tb_humidity_temp_frame_decode.sv
